// ===== design/rlc_pkg.sv =====
// Shared types, codes and reset constants for the rangefinder link controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rlc_pkg;

  // Default width of the wait timer
  localparam int TIMER_WIDTH_DEF = 16;

  // Item command codes
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_REQUEST = 2'd2;

  // Host request codes
  localparam logic [1:0] REQ_ON    = 2'd0;
  localparam logic [1:0] REQ_OFF   = 2'd1;
  localparam logic [1:0] REQ_RESET = 2'd2;

  // Completed frame kinds
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_DIST  = 2'd2;
  localparam logic [1:0] KIND_INIT  = 2'd3;

  // Frame bytes and lengths
  localparam logic [7:0] SYNC_BYTE = 8'hFB;
  localparam logic [7:0] TYPE_DIST = 8'h03;
  localparam logic [7:0] TYPE_ACK  = 8'h02;
  localparam logic [7:0] TYPE_INIT = 8'hFB;
  localparam logic [4:0] LEN_DIST  = 5'd24;
  localparam logic [4:0] LEN_SHORT = 5'd16;
  localparam logic [4:0] POS_DIST_LO = 5'd12;
  localparam logic [4:0] POS_DIST_HI = 5'd13;

  // Command codes sent to the module
  localparam logic [2:0] SEND_NONE  = 3'd0;
  localparam logic [2:0] SEND_OPEN  = 3'd1;
  localparam logic [2:0] SEND_RESET = 3'd2;
  localparam logic [2:0] SEND_START = 3'd3;
  localparam logic [2:0] SEND_STOP  = 3'd4;

  // Configuration register indexes
  localparam logic [7:0] REG_REPLY_TIMEOUT = 8'd0;
  localparam logic [7:0] REG_DATA_TIMEOUT  = 8'd1;
  localparam logic [7:0] REG_RETRY_DELAY   = 8'd2;
  localparam logic [7:0] REG_POWERUP_DELAY = 8'd3;

  // Configuration reset values
  localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd10;
  localparam logic [15:0] DATA_TIMEOUT_RST  = 16'd25;
  localparam logic [15:0] RETRY_DELAY_RST   = 16'd1000;
  localparam logic [15:0] POWERUP_DELAY_RST = 16'd200;

  // Classified item passed from the parser to the sequencer
  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  kind;
    logic [1:0]  req;
    logic [15:0] dist_value;
  } rlc_event_t;

  // Timing configuration
  typedef struct packed {
    logic [15:0] reply_timeout;
    logic [15:0] data_timeout;
    logic [15:0] retry_delay;
    logic [15:0] powerup_delay;
  } rlc_cfg_t;

endpackage

// ===== design/rlc_frame_parser.sv =====
// Front end: accepts items, runs the serial frame parser and classifies each item.
// Depends on rlc_pkg.
`timescale 1ns / 1ps

module rlc_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [7:0]         rx_byte,
  input  logic [1:0]         request,
  input  logic               q_full,
  output logic               push,
  output rlc_pkg::rlc_event_t push_event
);
  import rlc_pkg::*;

  logic [4:0] frame_count, frame_count_next;
  logic [4:0] frame_length, frame_length_next;
  logic [1:0] frame_kind, frame_kind_next;
  logic [7:0] distance_low, distance_low_next;
  logic [7:0] distance_high, distance_high_next;
  logic [1:0] done_kind;
  logic [4:0] count_inc;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  // Parser next state for a received byte
  always_comb begin
    frame_count_next   = frame_count;
    frame_length_next  = frame_length;
    frame_kind_next    = frame_kind;
    distance_low_next  = distance_low;
    distance_high_next = distance_high;
    done_kind          = KIND_EMPTY;
    count_inc          = frame_count + 5'd1;
    if (command == CMD_BYTE) begin
      if (frame_count == 5'd0) begin
        // hunting for sync
        if (rx_byte == SYNC_BYTE) begin
          frame_count_next = 5'd1;
        end else begin
          frame_length_next = 5'd0;
        end
      end else if (frame_count == 5'd1 && rx_byte != TYPE_DIST && rx_byte != TYPE_ACK &&
                   rx_byte != TYPE_INIT) begin
        // unknown type: resync
        frame_count_next  = 5'd0;
        frame_length_next = 5'd0;
        frame_kind_next   = KIND_EMPTY;
      end else begin
        if (frame_count == 5'd1) begin
          if (rx_byte == TYPE_DIST) begin
            frame_kind_next   = KIND_DIST;
            frame_length_next = LEN_DIST;
          end else if (rx_byte == TYPE_ACK) begin
            frame_kind_next   = KIND_ACK;
            frame_length_next = LEN_SHORT;
          end else begin
            frame_kind_next   = KIND_INIT;
            frame_length_next = LEN_SHORT;
          end
        end else if (frame_count == POS_DIST_LO) begin
          distance_low_next = rx_byte;
        end else if (frame_count == POS_DIST_HI) begin
          distance_high_next = rx_byte;
        end
        frame_count_next = count_inc;
        if (count_inc == frame_length_next) begin
          done_kind         = frame_kind_next;
          frame_count_next  = 5'd0;
          frame_length_next = 5'd0;
          frame_kind_next   = KIND_EMPTY;
        end
      end
    end
  end

  // Classified item toward the queue
  always_comb begin
    push_event.cmd        = command;
    push_event.kind       = done_kind;
    push_event.req        = request;
    push_event.dist_value = {distance_high_next, distance_low_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= 5'd0;
      frame_length  <= 5'd0;
      frame_kind    <= KIND_EMPTY;
      distance_low  <= 8'd0;
      distance_high <= 8'd0;
    end else if (accept) begin
      frame_count   <= frame_count_next;
      frame_length  <= frame_length_next;
      frame_kind    <= frame_kind_next;
      distance_low  <= distance_low_next;
      distance_high <= distance_high_next;
    end
  end

endmodule

// ===== design/rlc_event_queue.sv =====
// Two-entry queue of classified items between the parser and the sequencer.
// Depends on rlc_pkg.
`timescale 1ns / 1ps

module rlc_event_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rlc_pkg::rlc_event_t push_event,
  output logic                full,
  output logic                head_valid,
  output rlc_pkg::rlc_event_t head_event,
  input  logic                pop
);
  import rlc_pkg::*;

  rlc_event_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_event = entry[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_event;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== design/rlc_link_sequencer.sv =====
// Back end: link state machine, wait timer and registered result stage.
// Depends on rlc_pkg.
`timescale 1ns / 1ps

module rlc_link_sequencer #(
  parameter int TIMER_WIDTH = rlc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rlc_pkg::rlc_cfg_t   cfg,
  input  logic                ev_valid,
  input  rlc_pkg::rlc_event_t ev,
  output logic                ev_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          send_code,
  output logic                distance_valid,
  output logic [15:0]         distance,
  output logic [2:0]          link_state
);
  import rlc_pkg::*;

  localparam logic [2:0] ST_POWERUP     = 3'd0;
  localparam logic [2:0] ST_AWAIT_INIT  = 3'd1;
  localparam logic [2:0] ST_RETRY_WAIT  = 3'd2;
  localparam logic [2:0] ST_IDLE        = 3'd3;
  localparam logic [2:0] ST_AWAIT_START = 3'd4;
  localparam logic [2:0] ST_MEASURING   = 3'd5;
  localparam logic [2:0] ST_AWAIT_STOP  = 3'd6;

  localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);

  logic [2:0]             state, state_next;
  logic [TIMER_WIDTH-1:0] wait_timer, wait_timer_next;
  logic [2:0]             send;
  logic                   dvalid;
  logic [TIMER_WIDTH-1:0] reply_load;
  logic [TIMER_WIDTH-1:0] data_load;
  logic [TIMER_WIDTH-1:0] retry_load;

  assign reply_load = TIMER_WIDTH'(cfg.reply_timeout);
  assign data_load  = TIMER_WIDTH'(cfg.data_timeout);
  assign retry_load = TIMER_WIDTH'(cfg.retry_delay);

  // Take the next item whenever the result stage is free or being drained
  assign ev_pop = ev_valid && (!out_valid || !out_stall);

  // Next link state for the head item
  always_comb begin
    state_next      = state;
    wait_timer_next = wait_timer;
    send            = SEND_NONE;
    dvalid          = 1'b0;
    case (ev.cmd)
      CMD_BYTE: begin
        if (ev.kind != KIND_EMPTY) begin
          case (state)
            ST_AWAIT_INIT: begin
              state_next = ST_IDLE;
            end
            ST_AWAIT_START: begin
              if (ev.kind == KIND_ACK) begin
                state_next      = ST_MEASURING;
                wait_timer_next = data_load;
              end else begin
                send            = SEND_OPEN;
                state_next      = ST_AWAIT_INIT;
                wait_timer_next = reply_load;
              end
            end
            ST_MEASURING: begin
              if (ev.kind == KIND_DIST) begin
                dvalid          = 1'b1;
                wait_timer_next = data_load;
              end else begin
                send            = SEND_OPEN;
                state_next      = ST_AWAIT_INIT;
                wait_timer_next = reply_load;
              end
            end
            ST_AWAIT_STOP: begin
              if (ev.kind == KIND_ACK) begin
                state_next = ST_IDLE;
              end else begin
                send            = SEND_OPEN;
                state_next      = ST_AWAIT_INIT;
                wait_timer_next = reply_load;
              end
            end
            default: begin
              // frames in powerup, retry wait and idle are dropped
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (state != ST_IDLE) begin
          if (wait_timer > TIMER_ONE) begin
            wait_timer_next = wait_timer - TIMER_ONE;
          end else if (state == ST_AWAIT_INIT) begin
            send            = SEND_RESET;
            state_next      = ST_RETRY_WAIT;
            wait_timer_next = retry_load;
          end else begin
            send            = SEND_OPEN;
            state_next      = ST_AWAIT_INIT;
            wait_timer_next = reply_load;
          end
        end
      end
      CMD_REQUEST: begin
        if (state == ST_IDLE) begin
          if (ev.req == REQ_ON) begin
            send            = SEND_START;
            state_next      = ST_AWAIT_START;
            wait_timer_next = reply_load;
          end else if (ev.req == REQ_RESET) begin
            send            = SEND_OPEN;
            state_next      = ST_AWAIT_INIT;
            wait_timer_next = reply_load;
          end
        end else if (state == ST_MEASURING) begin
          if (ev.req == REQ_OFF) begin
            send            = SEND_STOP;
            state_next      = ST_AWAIT_STOP;
            wait_timer_next = reply_load;
          end else if (ev.req == REQ_RESET) begin
            send            = SEND_OPEN;
            state_next      = ST_AWAIT_INIT;
            wait_timer_next = reply_load;
          end
        end
      end
      default: begin
        // unused command: report state only
      end
    endcase
  end

  // Link state and timer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_POWERUP;
      wait_timer <= TIMER_WIDTH'(POWERUP_DELAY_RST);
    end else if (ev_pop) begin
      state      <= state_next;
      wait_timer <= wait_timer_next;
    end
  end

  // Result stage: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ev_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result stage: payload
  always_ff @(posedge clk) begin
    if (ev_pop) begin
      send_code      <= send;
      distance_valid <= dvalid;
      distance       <= dvalid ? ev.dist_value : 16'd0;
      link_state     <= state_next;
    end
  end

endmodule

// ===== design/rangefinder_link_controller_unit.sv =====
// Top level of the rangefinder link controller: configuration registers,
// parser front end, item queue and link sequencer. Depends on rlc_pkg and submodules.
`timescale 1ns / 1ps

// Each item (received byte, millisecond tick or host request) yields exactly one
// result: the command to send to the module, an optional distance and the link
// state after the item. Items are taken one per clock unless in_stall is high;
// an accepted item is written into the queue, popped by the link sequencer and
// its result registered in the result stage. A two-entry queue between the frame
// parser and the link sequencer, plus a registered result stage, let either side
// stall independently. Configuration writes are always ready; a new timeout or
// retry delay takes effect the next time the wait timer is loaded. After reset
// the block waits POWERUP_DELAY_RST ticks before sending the first open command.
module rangefinder_link_controller_unit #(
  parameter int TIMER_WIDTH = rlc_pkg::TIMER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  rx_byte,
  input  logic [1:0]  request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  send_code,
  output logic        distance_valid,
  output logic [15:0] distance,
  output logic [2:0]  link_state,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rlc_pkg::*;

  rlc_cfg_t   cfg;
  logic       q_full;
  logic       push;
  rlc_event_t push_event;
  logic       head_valid;
  rlc_event_t head_event;
  logic       pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reply_timeout <= REPLY_TIMEOUT_RST;
      cfg.data_timeout  <= DATA_TIMEOUT_RST;
      cfg.retry_delay   <= RETRY_DELAY_RST;
      cfg.powerup_delay <= POWERUP_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REPLY_TIMEOUT: cfg.reply_timeout <= cfg_data;
        REG_DATA_TIMEOUT:  cfg.data_timeout  <= cfg_data;
        REG_RETRY_DELAY:   cfg.retry_delay   <= cfg_data;
        REG_POWERUP_DELAY: cfg.powerup_delay <= cfg_data;
        default: begin
          // writes beyond the register list are ignored
        end
      endcase
    end
  end

  // Front end: parser
  rlc_frame_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .rx_byte    (rx_byte),
    .request    (request),
    .q_full     (q_full),
    .push       (push),
    .push_event (push_event)
  );

  // Queue between front and back
  rlc_event_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (q_full),
    .head_valid (head_valid),
    .head_event (head_event),
    .pop        (pop)
  );

  // Back end: link sequencer
  rlc_link_sequencer #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_sequencer (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .ev_valid       (head_valid),
    .ev             (head_event),
    .ev_pop         (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .send_code      (send_code),
    .distance_valid (distance_valid),
    .distance       (distance),
    .link_state     (link_state)
  );

endmodule
